### hdl/positional_list_insert_erase_reverse_core_macros.svh
// ----------------------------------------------------------------------------
// positional list core assertion macros
// shared concurrent assertion forms for the list core
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_ERASE_REVERSE_CORE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_ERASE_REVERSE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLIER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list core check failed");

// next-cycle implication, disabled during reset
`define PLIER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list core check failed");

`endif

### hdl/plier_pkg.sv
// ----------------------------------------------------------------------------
// plier_pkg
// shared types and constants of the positional list core
// ----------------------------------------------------------------------------
package plier_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 7;
    localparam int COUNT_W      = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // what every cell does at the next edge
    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_NOP,
        CELL_INSERT,
        CELL_ERASE,
        CELL_READ
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   data;
    } cell_ctrl_t;

endpackage

### hdl/plier_cell.sv
// ----------------------------------------------------------------------------
// plier_cell
// one storage slot of the list, shifts with its neighbors on insert/erase
// ----------------------------------------------------------------------------
module plier_cell #(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  plier_pkg::cell_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]              idx,
    input  logic [plier_pkg::DATA_W-1:0]  lower,
    input  logic [plier_pkg::DATA_W-1:0]  upper,
    output logic [plier_pkg::DATA_W-1:0]  entry,
    output logic [plier_pkg::DATA_W-1:0]  hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [plier_pkg::DATA_W-1:0] entry_reg;
    logic [plier_pkg::DATA_W-1:0] hit_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            plier_pkg::CELL_INSERT:
            begin
                if (idx == MY_IDX)
                begin
                    entry_reg <= ctrl.data;
                end
                else if (idx < MY_IDX)
                begin
                    entry_reg <= lower;
                end
            end
            plier_pkg::CELL_ERASE:
            begin
                if (idx <= MY_IDX)
                begin
                    entry_reg <= upper;
                end
            end
            default:
            begin
            end
        endcase

        // every request reloads the read word, so only the addressed slot of a read shows
        if (ctrl.op != plier_pkg::CELL_IDLE)
        begin
            hit_reg <= (ctrl.op == plier_pkg::CELL_READ && idx == MY_IDX) ? entry_reg : '0;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

### hdl/positional_list_insert_erase_reverse_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_erase_reverse_core
// bounded ordered list of signed 32-bit values with insert, erase, reverse, read
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the command (insert,
// erase, reverse, read), tdata the signed position and the value to insert.
// Every request gives exactly one result on m_axis: tuser holds the ok flag,
// tdata the length after the command and the value read (zero otherwise).
// The entries sit in a row of cells; insert and erase shift every cell above
// the position by one slot in the cycle the request is accepted. Reverse only
// flips an orientation bit, and logical positions are mapped onto the cells.
// A read takes the addressed cell's word into a per-cell register and the
// words are or-ed into the result register when the s1 stage hands its result on.
// A result passes the s1 register and then the output register; one request is
// taken every cycle unless the receiver stalls; the cell row updates on accept.
// After reset the list is empty and not reversed; cell contents are unknown
// until written and never shown. When the receiver stalls, one result waits
// in the output register and one in the stage before it, after which
// s_axis_tready drops until the output register is taken.
// ----------------------------------------------------------------------------
`include "positional_list_insert_erase_reverse_core_macros.svh"

module positional_list_insert_erase_reverse_core #(
    parameter int CAPACITY = plier_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position[6:0], data_in[38:7], zero pad
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // count[5:0], data_out[37:6], zero pad
    output logic [0:0]  m_axis_tuser   // ok[0]
);

    localparam int DATA_W  = plier_pkg::DATA_W;
    localparam int POS_W   = plier_pkg::POS_W;
    localparam int COUNT_W = plier_pkg::COUNT_W;
    localparam int FILL_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CMP_W   = (FILL_W > POS_W) ? FILL_W : POS_W;

    // request fields
    plier_pkg::cmd_t              cmd;
    logic signed [POS_W-1:0]      position;
    logic [DATA_W-1:0]            data_in;

    assign cmd      = plier_pkg::cmd_t'(s_axis_tuser);
    assign position = s_axis_tdata[POS_W-1:0];
    assign data_in  = s_axis_tdata[POS_W +: DATA_W];

    logic                 accept;
    logic                 s1_move;

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic                 rev_reg;
    logic                 rev_next;

    logic                 s1_valid_reg;
    logic                 s1_ok_reg;
    logic                 s1_ok_next;
    logic [COUNT_W-1:0]   s1_count_reg;

    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [DATA_W-1:0]    out_data_reg;

    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     fill_ext;
    logic [CMP_W-1:0]     fill_next_ext;
    logic [CMP_W-1:0]     phys_ext;
    logic                 ins_ok;
    logic                 idx_ok;
    logic [IDX_W-1:0]     cell_idx;

    plier_pkg::cell_op_t  op;
    plier_pkg::cell_ctrl_t cell_ctrl;

    logic [DATA_W-1:0]    ent  [CAPACITY];
    logic [DATA_W-1:0]    hits [CAPACITY];
    logic [DATA_W-1:0]    read_word;

    logic                 ins_req;
    logic                 rej_req;
    logic                 both_full;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // range checks and logical to cell position mapping
    assign pos_ext  = CMP_W'(position[POS_W-2:0]);
    assign fill_ext = CMP_W'(fill_reg);
    assign ins_ok   = !position[POS_W-1] && (pos_ext <= fill_ext)
                      && (fill_reg < FILL_W'(CAPACITY));
    assign idx_ok   = !position[POS_W-1] && (pos_ext < fill_ext);

    always_comb
    begin
        if (rev_reg)
        begin
            // reversed: insert lands at fill-pos, others address fill-1-pos
            if (cmd == plier_pkg::CMD_INSERT)
            begin
                phys_ext = fill_ext - pos_ext;
            end
            else
            begin
                phys_ext = fill_ext - pos_ext - CMP_W'(1);
            end
        end
        else
        begin
            phys_ext = pos_ext;
        end
    end

    assign cell_idx = phys_ext[IDX_W-1:0];

    always_comb
    begin
        op         = plier_pkg::CELL_NOP;
        s1_ok_next = 1'b0;
        fill_next  = fill_reg;
        rev_next   = rev_reg;
        unique case (cmd)
            plier_pkg::CMD_INSERT:
            begin
                s1_ok_next = ins_ok;
                if (ins_ok)
                begin
                    op        = plier_pkg::CELL_INSERT;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            plier_pkg::CMD_ERASE:
            begin
                s1_ok_next = idx_ok;
                if (idx_ok)
                begin
                    op        = plier_pkg::CELL_ERASE;
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            plier_pkg::CMD_REVERSE:
            begin
                s1_ok_next = 1'b1;
                rev_next   = !rev_reg;
            end
            plier_pkg::CMD_READ:
            begin
                s1_ok_next = idx_ok;
                if (idx_ok)
                begin
                    op = plier_pkg::CELL_READ;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign fill_next_ext  = CMP_W'(fill_next);
    assign cell_ctrl.op   = accept ? op : plier_pkg::CELL_IDLE;
    assign cell_ctrl.data = data_in;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (i == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = ent[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = ent[i];
        end
        else
        begin : g_upper
            assign upper = ent[i+1];
        end

        plier_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl),
            .idx   (cell_idx),
            .lower (lower),
            .upper (upper),
            .entry (ent[i]),
            .hit   (hits[i])
        );
    end

    always_comb
    begin
        read_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_word = read_word | hits[k];
        end
    end

    // list state and result pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rev_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
                rev_reg  <= rev_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_count_reg <= fill_next_ext[COUNT_W-1:0];
        end
        if (s1_move)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_count_reg <= s1_count_reg;
            out_data_reg  <= read_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {{(40 - COUNT_W - DATA_W){1'b0}}, out_data_reg, out_count_reg};

    // checks
    assign ins_req   = accept && cmd == plier_pkg::CMD_INSERT && ins_ok;
    assign rej_req   = accept && !s1_ok_next;
    assign both_full = s1_valid_reg && out_valid_reg;

    `PLIER_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(CAPACITY))
    `PLIER_ASSERT_NEXT(a_ins_grows, clk, rst_n, ins_req, fill_reg == $past(fill_reg) + FILL_W'(1))
    `PLIER_ASSERT_NEXT(a_rej_keeps, clk, rst_n, rej_req, fill_reg == $past(fill_reg) && s1_valid_reg)
    `PLIER_ASSERT_NEXT(a_stage_holds, clk, rst_n, both_full && !m_axis_tready, both_full)

endmodule
